### design/vtdi_pkg.sv
package vtdi_pkg;

   localparam int NUM_ATTR   = 5;
   localparam int FIELD_BITS = 24;
   localparam int VIDX_BITS  = 12;
   localparam int MASK_BITS  = 5;
   localparam int CNT_BITS   = 3;

   localparam logic [MASK_BITS-1:0] MASK_RESET = 5'b00001;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pos_index;
      logic [FIELD_BITS-1:0] normal_index;
      logic [FIELD_BITS-1:0] color_index;
      logic [FIELD_BITS-1:0] tex_one_index;
      logic [FIELD_BITS-1:0] tex_two_index;
   } req_word_type;

   typedef struct packed {
      logic [VIDX_BITS-1:0] vertex_index;
      logic                 is_new;
      logic                 overflow;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HASH  = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

endpackage

### design/vtdi_table.sv
module vtdi_table #(
   parameter int DEPTH      = 4096,
   parameter int ADDR_BITS  = 12,
   parameter int ENTRY_BITS = 139
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [ENTRY_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [ENTRY_BITS-1:0] rd_data
);

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/vertex_tuple_dedup_indexer_core.sv
// Vertex tuple deduplication indexer.
// A word on the req_ channel carries the five attribute indices of one vertex
// corner. The attributes enabled in the mask register (csr_ port, one write
// enable and 5 bits of data, reset value 1) form the key. Each request gives
// exactly one word on the rsp_ channel: the vertex index first given to that
// key, or a fresh sequential index with is_new set, or overflow set when the
// table already holds TABLE_DEPTH keys.
// The keys live in one open-addressed hash table in a synchronous memory,
// probed linearly, one probe per cycle. A request is taken in the idle state,
// the home slot is read in the next cycle and checked in the one after. Each
// further probe reads the next slot, wrapping round at the end of the table,
// until the key or an empty slot is found or every slot has been probed.
// An insert is written in the same cycle it is decided, before the next read.
// After reset the table is swept clear, one entry per cycle; req_stall stays
// high during that sweep. Mask writes are taken then. The result sits in an
// output register; while rsp_stall holds it, the next request is still
// accepted and worked on up to the point of its own result.

module vertex_tuple_dedup_indexer_core #(
   parameter int TABLE_DEPTH = 4096,
   parameter int INDEX_BITS  = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [vtdi_pkg::MASK_BITS-1:0]      csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vtdi_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vtdi_pkg::rsp_word_type              rsp_word
);

   import vtdi_pkg::*;

   localparam int AW         = $clog2(TABLE_DEPTH);
   localparam int KEY_BITS   = NUM_ATTR * INDEX_BITS;
   localparam int HSRC_BITS  = KEY_BITS + CNT_BITS;
   localparam int ENTRY_BITS = 1 + CNT_BITS + KEY_BITS + VIDX_BITS;

   state_type                  state_ff, state_in;
   logic [MASK_BITS-1:0]       mask_ff, mask_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic [AW:0]                count_ff, count_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic [CNT_BITS-1:0]        kcnt_ff, kcnt_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [AW-1:0]              probe_ff, probe_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   logic [NUM_ATTR-1:0][31:0]         raw_fields;
   logic [NUM_ATTR-1:0][INDEX_BITS-1:0] packed_key;
   logic [CNT_BITS-1:0]               packed_cnt;
   logic [HSRC_BITS-1:0]              hash_src;
   logic [AW-1:0]                     hash_fold;
   logic [AW-1:0]                     hash_addr;
   logic [AW-1:0]                     next_addr;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;

   logic                  e_valid;
   logic [CNT_BITS-1:0]   e_cnt;
   logic [KEY_BITS-1:0]   e_key;
   logic [VIDX_BITS-1:0]  e_vidx;
   logic                  hit;
   logic                  done;
   logic                  rsp_free;
   logic                  accept;
   logic [31:0]           count_wide;
   logic [VIDX_BITS-1:0]  new_vidx;

   vtdi_table #(
      .DEPTH      (TABLE_DEPTH),
      .ADDR_BITS  (AW),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Enabled attributes are packed to the front in attribute order; the tail
   // stays zero, so two keys match exactly when count and packed bits match.
   always_comb begin
      raw_fields[0] = 32'(req_word.pos_index);
      raw_fields[1] = 32'(req_word.normal_index);
      raw_fields[2] = 32'(req_word.color_index);
      raw_fields[3] = 32'(req_word.tex_one_index);
      raw_fields[4] = 32'(req_word.tex_two_index);
      packed_key = '0;
      packed_cnt = '0;
      for (int i = 0; i < NUM_ATTR; i++) begin
         if (mask_ff[i]) begin
            packed_key[packed_cnt] = raw_fields[i][INDEX_BITS-1:0];
            packed_cnt = packed_cnt + 3'd1;
         end
      end
   end

   always_comb begin
      hash_src  = {kcnt_ff, key_ff};
      hash_fold = '0;
      for (int i = 0; i < HSRC_BITS; i++) begin
         hash_fold[i % AW] = hash_fold[i % AW] ^ hash_src[i];
      end
      if ({1'b0, hash_fold} >= (AW+1)'(TABLE_DEPTH)) begin
         hash_addr = hash_fold - AW'(TABLE_DEPTH);
      end else begin
         hash_addr = hash_fold;
      end
   end

   assign next_addr = (addr_ff == AW'(TABLE_DEPTH - 1)) ? '0 : addr_ff + 1'b1;

   assign {e_valid, e_cnt, e_key, e_vidx} = rd_data;
   assign hit      = e_valid && (e_cnt == kcnt_ff) && (e_key == key_ff);
   assign done     = hit || !e_valid || (probe_ff == AW'(TABLE_DEPTH - 1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == ST_IDLE);

   assign count_wide = 32'(count_ff);
   assign new_vidx   = count_wide[VIDX_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      mask_in      = csr_write_enable ? csr_write_data : mask_ff;
      clr_addr_in  = clr_addr_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      kcnt_in      = kcnt_ff;
      addr_in      = addr_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = hash_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               key_in   = packed_key;
               kcnt_in  = packed_cnt;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            rd_en    = 1'b1;
            rd_addr  = hash_addr;
            addr_in  = hash_addr;
            probe_in = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!done) begin
               rd_en    = 1'b1;
               rd_addr  = next_addr;
               addr_in  = next_addr;
               probe_in = probe_ff + 1'b1;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               priority if (hit) begin
                  rsp_word_in = '{vertex_index: e_vidx, is_new: 1'b0, overflow: 1'b0};
               end else if (!e_valid && (count_ff != (AW+1)'(TABLE_DEPTH))) begin
                  wr_en       = 1'b1;
                  wr_addr     = addr_ff;
                  wr_data     = {1'b1, kcnt_ff, key_ff, new_vidx};
                  count_in    = count_ff + 1'b1;
                  rsp_word_in = '{vertex_index: new_vidx, is_new: 1'b1, overflow: 1'b0};
               end else begin
                  rsp_word_in = '{vertex_index: '0, is_new: 1'b0, overflow: 1'b1};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mask_ff      <= MASK_RESET;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      kcnt_ff     <= kcnt_in;
      addr_ff     <= addr_in;
      probe_ff    <= probe_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
